// ===== hdl/bellman_ford_shortest_paths_assert.svh =====
// Assertion macros for the checker of the shortest-path block.
`ifndef BELLMAN_FORD_SHORTEST_PATHS_ASSERT_SVH
`define BELLMAN_FORD_SHORTEST_PATHS_ASSERT_SVH

// Next-cycle implication, checked only outside reset.
`define BFSP_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

// Next-cycle implication that is also checked across reset.
`define BFSP_ASSERT_ALWAYS(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) (pre) |=> (post)) else $error(msg);

`endif

// ===== hdl/bfsp_pkg.sv =====
// Package with the shared widths, register indexes and types of the shortest-path block.
package bfsp_pkg;

  // Field widths fixed by the channel and register definitions.
  localparam int VID_W      = 6;
  localparam int WIN_W      = 16;
  localparam int DIST_W     = 32;
  localparam int VCNT_W     = 7;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_VERTEX_COUNT  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_VERTEX = 1'b1;

  // One entry of the vertex state memory.
  typedef struct packed {
    logic signed [DIST_W-1:0] path_len;
    logic                     reach;
    logic                     has_par;
    logic [VID_W-1:0]         par;
  } vtx_entry_t;

  // Outcome of trying one edge.
  typedef struct packed {
    logic                     improve;
    logic signed [DIST_W-1:0] sum;
  } relax_res_t;

endpackage

// ===== hdl/bfsp_if.sv =====
// Stream interfaces for the edge input channel and the vertex result channel.
interface bfsp_in_if;
  logic                               valid;
  logic                               ready;
  logic [bfsp_pkg::VID_W-1:0]         from_vertex;
  logic [bfsp_pkg::VID_W-1:0]         to_vertex;
  logic signed [bfsp_pkg::WIN_W-1:0]  weight;
  logic                               last_edge;

  modport source (output valid, from_vertex, to_vertex, weight, last_edge, input ready);
  modport sink   (input valid, from_vertex, to_vertex, weight, last_edge, output ready);
endinterface

interface bfsp_out_if;
  logic                               valid;
  logic                               ready;
  logic [bfsp_pkg::VID_W-1:0]         vertex;
  logic signed [bfsp_pkg::DIST_W-1:0] distance;
  logic                               reachable;
  logic [bfsp_pkg::VID_W-1:0]         parent;
  logic                               has_parent;
  logic                               no_negative_cycle;
  logic                               last_vertex;

  modport source (output valid, vertex, distance, reachable, parent, has_parent,
                  no_negative_cycle, last_vertex, input ready);
  modport sink   (input valid, vertex, distance, reachable, parent, has_parent,
                  no_negative_cycle, last_vertex, output ready);
endinterface

// ===== hdl/bellman_ford_shortest_paths.sv =====
// Edge beats load at one per cycle while idle; the beat marked last starts a run.
// A run first initializes the vertex memory, then reads and evaluates every stored edge
// for each of the n-1 passes and the cycle check, then offers one result per vertex.
// Per-edge cost is the read-modify-write of the vertex memory after the edge table read.
// Synchronous active-low reset clears control state and the edge count; the memories
// are not cleared, vertex entries are written by the initialization sweep of each run.
module bellman_ford_shortest_paths #(
  parameter int MAX_VERTICES = 64,
  parameter int MAX_EDGES    = 256,
  parameter int WEIGHT_BITS  = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [bfsp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bfsp_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  bfsp_in_if.sink                             in_ch,
  bfsp_out_if.source                          out_ch
);

  localparam int VAW    = $clog2(MAX_VERTICES);
  localparam int EAW    = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int ECW    = $clog2(MAX_EDGES + 1);
  localparam int EDGE_W = 2 * bfsp_pkg::VID_W + WEIGHT_BITS;
  localparam int RAW_W  = (WEIGHT_BITS > bfsp_pkg::WIN_W) ? WEIGHT_BITS : bfsp_pkg::WIN_W;
  localparam logic [bfsp_pkg::VCNT_W-1:0] NV   = bfsp_pkg::VCNT_W'(MAX_VERTICES);
  localparam logic [ECW-1:0]              EMAX = ECW'(MAX_EDGES);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_CLEAR  = 6'b000010,
    S_VRD    = 6'b000100,
    S_EVAL   = 6'b001000,
    S_OUT_RD = 6'b010000,
    S_OUT_LD = 6'b100000
  } state_t;

  state_t                           state_r, state_nxt;
  logic [bfsp_pkg::VCNT_W-1:0]      vcount_r;
  logic [bfsp_pkg::VID_W-1:0]       src_r;
  logic [bfsp_pkg::VCNT_W-1:0]      n_r, n_nxt;
  logic [bfsp_pkg::VID_W-1:0]       run_src_r, run_src_nxt;
  logic [ECW-1:0]                   ecnt_r, ecnt_nxt;
  logic [EAW-1:0]                   eidx_r, eidx_nxt;
  logic [bfsp_pkg::VCNT_W-1:0]      pass_r, pass_nxt;
  logic                             check_r, check_nxt;
  logic                             clean_r, clean_nxt;
  logic [bfsp_pkg::VID_W-1:0]       vidx_r, vidx_nxt;
  logic                             out_valid_r, out_valid_nxt;
  logic [bfsp_pkg::VID_W-1:0]       out_vertex_r;
  logic signed [bfsp_pkg::DIST_W-1:0] out_dist_r;
  logic                             out_reach_r;
  logic [bfsp_pkg::VID_W-1:0]       out_parent_r;
  logic                             out_has_par_r;
  logic                             out_clean_r;
  logic                             out_last_r;

  logic                             in_accept;
  logic [bfsp_pkg::VCNT_W-1:0]      n_clamped;
  logic [RAW_W-1:0]                 raw_w;
  logic                             e_we;
  logic [EDGE_W-1:0]                e_wdata;
  logic [EDGE_W-1:0]                e_rdata;
  logic [bfsp_pkg::VID_W-1:0]       ed_from;
  logic [bfsp_pkg::VID_W-1:0]       ed_to;
  logic signed [WEIGHT_BITS-1:0]    ed_w;
  logic                             v_we;
  logic [VAW-1:0]                   v_waddr;
  bfsp_pkg::vtx_entry_t             v_wdata;
  logic [VAW-1:0]                   v_raddr_a;
  bfsp_pkg::vtx_entry_t             v_rdata_a;
  bfsp_pkg::vtx_entry_t             v_rdata_b;
  bfsp_pkg::relax_res_t             rlx;
  logic                             vidx_last;
  logic                             edge_last;
  logic                             out_free;
  logic                             out_load;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcount_r <= bfsp_pkg::VCNT_W'(1);
      src_r    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bfsp_pkg::REG_VERTEX_COUNT:  vcount_r <= cfg_wdata;
        bfsp_pkg::REG_SOURCE_VERTEX: src_r    <= cfg_wdata[bfsp_pkg::VID_W-1:0];
        default: ;
      endcase
    end
  end

  // Vertex count in use, clamped to the supported range.
  always_comb begin
    if (vcount_r == '0) begin
      n_clamped = bfsp_pkg::VCNT_W'(1);
    end else if (vcount_r > NV) begin
      n_clamped = NV;
    end else begin
      n_clamped = vcount_r;
    end
  end

  // Edge load: the low weight bits are kept and later read back as signed.
  assign in_accept   = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE);
  assign raw_w       = RAW_W'($unsigned(in_ch.weight));
  assign e_we        = in_accept && (ecnt_r < EMAX);
  assign e_wdata     = {in_ch.from_vertex, in_ch.to_vertex, raw_w[WEIGHT_BITS-1:0]};

  bfsp_edge_ram #(
    .DEPTH (MAX_EDGES),
    .WIDTH (EDGE_W),
    .AW    (EAW)
  ) u_edge_ram (
    .clk   (clk),
    .we    (e_we),
    .waddr (ecnt_r[EAW-1:0]),
    .wdata (e_wdata),
    .raddr (eidx_nxt),
    .rdata (e_rdata)
  );

  assign ed_from = e_rdata[EDGE_W-1 -: bfsp_pkg::VID_W];
  assign ed_to   = e_rdata[WEIGHT_BITS +: bfsp_pkg::VID_W];
  assign ed_w    = e_rdata[WEIGHT_BITS-1:0];

  // Vertex memory port A reads the tail or the result vertex, port B the head.
  assign v_raddr_a = ((state_r == S_OUT_RD) || (state_r == S_OUT_LD)) ?
                     vidx_r[VAW-1:0] : ed_from[VAW-1:0];

  bfsp_vtx_ram #(
    .DEPTH (MAX_VERTICES),
    .AW    (VAW)
  ) u_vtx_ram (
    .clk     (clk),
    .we      (v_we),
    .waddr   (v_waddr),
    .wdata   (v_wdata),
    .raddr_a (v_raddr_a),
    .raddr_b (ed_to[VAW-1:0]),
    .rdata_a (v_rdata_a),
    .rdata_b (v_rdata_b)
  );

  bfsp_relax #(
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_relax (
    .from_v (ed_from),
    .to_v   (ed_to),
    .weight (ed_w),
    .from_e (v_rdata_a),
    .to_e   (v_rdata_b),
    .n      (n_r),
    .res    (rlx)
  );

  // Vertex memory writes: the initialization sweep or an improving edge.
  always_comb begin
    v_we             = 1'b0;
    v_waddr          = vidx_r[VAW-1:0];
    v_wdata.path_len = '0;
    v_wdata.reach    = (vidx_r == run_src_r);
    v_wdata.has_par  = 1'b0;
    v_wdata.par      = '0;
    if (state_r == S_CLEAR) begin
      v_we = 1'b1;
    end else if ((state_r == S_EVAL) && !check_r && rlx.improve) begin
      v_we             = 1'b1;
      v_waddr          = ed_to[VAW-1:0];
      v_wdata.path_len = rlx.sum;
      v_wdata.reach    = 1'b1;
      v_wdata.has_par  = 1'b1;
      v_wdata.par      = ed_from;
    end
  end

  assign vidx_last = ({1'b0, vidx_r} == (n_r - bfsp_pkg::VCNT_W'(1)));
  assign edge_last = ((ECW'(eidx_r) + ECW'(1)) == ecnt_r);
  assign out_free  = !out_valid_r || out_ch.ready;
  assign out_load  = (state_r == S_OUT_LD);

  // Run sequencer.
  always_comb begin
    state_nxt     = state_r;
    n_nxt         = n_r;
    run_src_nxt   = run_src_r;
    ecnt_nxt      = ecnt_r;
    eidx_nxt      = eidx_r;
    pass_nxt      = pass_r;
    check_nxt     = check_r;
    clean_nxt     = clean_r;
    vidx_nxt      = vidx_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    unique case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          if (ecnt_r < EMAX) begin
            ecnt_nxt = ecnt_r + ECW'(1);
          end
          if (in_ch.last_edge) begin
            n_nxt       = n_clamped;
            run_src_nxt = src_r;
            vidx_nxt    = '0;
            eidx_nxt    = '0;
            state_nxt   = S_CLEAR;
          end
        end
      end
      S_CLEAR: begin
        eidx_nxt = '0;
        if (vidx_last) begin
          pass_nxt  = bfsp_pkg::VCNT_W'(1);
          check_nxt = (n_r == bfsp_pkg::VCNT_W'(1));
          clean_nxt = 1'b1;
          state_nxt = S_VRD;
        end else begin
          vidx_nxt = vidx_r + bfsp_pkg::VID_W'(1);
        end
      end
      S_VRD: begin
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        if (check_r && rlx.improve) begin
          clean_nxt = 1'b0;
        end
        if (!edge_last) begin
          eidx_nxt  = eidx_r + EAW'(1);
          state_nxt = S_VRD;
        end else if (check_r) begin
          vidx_nxt  = '0;
          state_nxt = S_OUT_RD;
        end else begin
          eidx_nxt  = '0;
          state_nxt = S_VRD;
          if ((pass_r + bfsp_pkg::VCNT_W'(1)) == n_r) begin
            check_nxt = 1'b1;
          end else begin
            pass_nxt = pass_r + bfsp_pkg::VCNT_W'(1);
          end
        end
      end
      S_OUT_RD: begin
        if (out_free) begin
          state_nxt = S_OUT_LD;
        end
      end
      S_OUT_LD: begin
        out_valid_nxt = 1'b1;
        if (vidx_last) begin
          ecnt_nxt  = '0;
          state_nxt = S_IDLE;
        end else begin
          vidx_nxt  = vidx_r + bfsp_pkg::VID_W'(1);
          state_nxt = S_OUT_RD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      n_r         <= bfsp_pkg::VCNT_W'(1);
      run_src_r   <= '0;
      ecnt_r      <= '0;
      eidx_r      <= '0;
      pass_r      <= '0;
      check_r     <= 1'b0;
      clean_r     <= 1'b1;
      vidx_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      n_r         <= n_nxt;
      run_src_r   <= run_src_nxt;
      ecnt_r      <= ecnt_nxt;
      eidx_r      <= eidx_nxt;
      pass_r      <= pass_nxt;
      check_r     <= check_nxt;
      clean_r     <= clean_nxt;
      vidx_r      <= vidx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result register, loaded from the vertex memory read of the current vertex.
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_vertex_r  <= vidx_r;
      out_dist_r    <= v_rdata_a.reach ? v_rdata_a.path_len : '0;
      out_reach_r   <= v_rdata_a.reach;
      out_parent_r  <= (v_rdata_a.reach && v_rdata_a.has_par) ? v_rdata_a.par : '0;
      out_has_par_r <= v_rdata_a.reach && v_rdata_a.has_par;
      out_clean_r   <= clean_r;
      out_last_r    <= vidx_last;
    end
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.vertex            = out_vertex_r;
  assign out_ch.distance          = out_dist_r;
  assign out_ch.reachable         = out_reach_r;
  assign out_ch.parent            = out_parent_r;
  assign out_ch.has_parent        = out_has_par_r;
  assign out_ch.no_negative_cycle = out_clean_r;
  assign out_ch.last_vertex       = out_last_r;

endmodule

// ===== hdl/bfsp_edge_ram.sv =====
// Edge table memory: one write port, one read port with registered read data.
module bfsp_edge_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 28,
  parameter int AW    = 8
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/bfsp_vtx_ram.sv =====
// Vertex state memory: one write port, two read ports with registered read data.
module bfsp_vtx_ram #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [AW-1:0]        waddr,
  input  bfsp_pkg::vtx_entry_t wdata,
  input  logic [AW-1:0]        raddr_a,
  input  logic [AW-1:0]        raddr_b,
  output bfsp_pkg::vtx_entry_t rdata_a,
  output bfsp_pkg::vtx_entry_t rdata_b
);

  bfsp_pkg::vtx_entry_t mem [DEPTH];
  bfsp_pkg::vtx_entry_t rdata_a_r;
  bfsp_pkg::vtx_entry_t rdata_b_r;

  // Write and both registered reads.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a_r <= mem[raddr_a];
    rdata_b_r <= mem[raddr_b];
  end

  assign rdata_a = rdata_a_r;
  assign rdata_b = rdata_b_r;

endmodule

// ===== hdl/bfsp_relax.sv =====
// Relaxation datapath: saturating distance sum and strict-less improvement test.
module bfsp_relax #(
  parameter int WEIGHT_BITS = 16
) (
  input  logic [bfsp_pkg::VID_W-1:0]  from_v,
  input  logic [bfsp_pkg::VID_W-1:0]  to_v,
  input  logic signed [WEIGHT_BITS-1:0] weight,
  input  bfsp_pkg::vtx_entry_t        from_e,
  input  bfsp_pkg::vtx_entry_t        to_e,
  input  logic [bfsp_pkg::VCNT_W-1:0] n,
  output bfsp_pkg::relax_res_t        res
);

  localparam int SW = bfsp_pkg::DIST_W + 1;

  logic signed [SW-1:0]                  wide_sum;
  logic signed [bfsp_pkg::DIST_W-1:0]    sat_sum;
  logic                                  in_range;

  // Sum one bit wider than a distance, then clamp on overflow.
  always_comb begin
    wide_sum = {from_e.path_len[bfsp_pkg::DIST_W-1], from_e.path_len}
             + {{(SW-WEIGHT_BITS){weight[WEIGHT_BITS-1]}}, weight};
    if (wide_sum[SW-1] != wide_sum[SW-2]) begin
      sat_sum = wide_sum[SW-1] ? {1'b1, {(bfsp_pkg::DIST_W-1){1'b0}}}
                               : {1'b0, {(bfsp_pkg::DIST_W-1){1'b1}}};
    end else begin
      sat_sum = wide_sum[bfsp_pkg::DIST_W-1:0];
    end
  end

  // Both endpoints must lie inside the graph in use.
  assign in_range = ({1'b0, from_v} < n) && ({1'b0, to_v} < n);

  assign res.sum     = sat_sum;
  assign res.improve = in_range && from_e.reach &&
                       (!to_e.reach || ($signed(sat_sum) < $signed(to_e.path_len)));

endmodule

// ===== hdl/bfsp_checker.sv =====
// Port-level checker for the shortest-path block, bound to its top level.
`include "bellman_ford_shortest_paths_assert.svh"

module bfsp_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic in_last,
  input logic out_valid,
  input logic out_ready,
  input logic out_last
);

  // A result beat stays offered until it is taken.
  `BFSP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result beat dropped while stalled")

  // The last edge beat starts a run, so no edge is taken in the next cycle.
  `BFSP_ASSERT_NEXT(a_run_starts, in_valid && in_ready && in_last, !in_ready, "edge taken right after last edge")

  // Inside a result burst the edge channel stays closed.
  `BFSP_ASSERT_NEXT(a_burst_closed, out_valid && out_ready && !out_last, !in_ready, "edge taken during result burst")

  // Reset leaves no result on offer.
  `BFSP_ASSERT_ALWAYS(a_reset_quiet, !rst_n, !out_valid, "result offered after reset")

endmodule

bind bellman_ford_shortest_paths bfsp_checker u_bfsp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_last   (in_ch.last_edge),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_last  (out_ch.last_vertex)
);

// ===== dv/bellman_ford_shortest_paths_tb.sv =====
// Self-checking testbench for the shortest-path block: directed and random graphs, stalls, predictor.
module bellman_ford_shortest_paths_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int     MAX_V       = 64;
  localparam int     MAX_E       = 256;
  localparam int     QUIET_LIMIT = 200000;
  localparam int     RANDOM_EDGES = 104;
  localparam longint DIST_MAX    = 64'sd2147483647;
  localparam longint DIST_MIN    = -64'sd2147483648;

  // One stored edge of the graph under test.
  typedef struct packed {
    logic [bfsp_pkg::VID_W-1:0]        tail;
    logic [bfsp_pkg::VID_W-1:0]        head;
    logic signed [bfsp_pkg::WIN_W-1:0] weight;
  } edge_t;

  // One per-vertex result beat.
  typedef struct packed {
    logic [bfsp_pkg::VID_W-1:0]         vertex;
    logic signed [bfsp_pkg::DIST_W-1:0] distance;
    logic                               reachable;
    logic [bfsp_pkg::VID_W-1:0]         parent;
    logic                               has_parent;
    logic                               no_neg_cycle;
    logic                               last_vertex;
  } vertex_result_t;

  // Tracks loaded edges, solves each graph and checks the per-vertex results.
  class distance_scoreboard;
    logic [bfsp_pkg::VCNT_W-1:0] vertex_count;
    logic [bfsp_pkg::VID_W-1:0]  source_vertex;
    edge_t                       edges[$];
    vertex_result_t              pending_vertices[$];
    int                          errors;
    int                          path_len[MAX_V];
    bit                          reach[MAX_V];
    bit                          has_par[MAX_V];
    logic [bfsp_pkg::VID_W-1:0]  par[MAX_V];

    function new();
      vertex_count  = 1;
      source_vertex = 0;
      errors        = 0;
    endfunction

    function void write_reg(logic [bfsp_pkg::CFG_IDX_W-1:0] idx,
                            logic [bfsp_pkg::CFG_DATA_W-1:0] data);
      if (idx == bfsp_pkg::REG_VERTEX_COUNT) begin
        vertex_count = data[bfsp_pkg::VCNT_W-1:0];
      end else if (idx == bfsp_pkg::REG_SOURCE_VERTEX) begin
        source_vertex = data[bfsp_pkg::VID_W-1:0];
      end
    endfunction

    function int outstanding();
      return pending_vertices.size();
    endfunction

    // Tries one edge against the current distances; strict-less, saturating sum.
    function bit try_edge(edge_t e, int n, output int sum);
      longint s;
      sum = 0;
      if (e.tail >= n || e.head >= n) return 0;
      if (!reach[e.tail]) return 0;
      s = longint'(path_len[e.tail]) + longint'($signed(e.weight));
      if (s > DIST_MAX) s = DIST_MAX;
      else if (s < DIST_MIN) s = DIST_MIN;
      sum = int'(s);
      return !reach[e.head] || sum < path_len[e.head];
    endfunction

    // Runs the relaxation passes and the cycle check, then queues one result per vertex.
    function void relax_graph();
      int             n;
      int             sum;
      bit             clean;
      vertex_result_t r;
      n = vertex_count;
      if (n == 0) n = 1;
      if (n > MAX_V) n = MAX_V;
      for (int v = 0; v < MAX_V; v++) begin
        path_len[v] = 0;
        reach[v]    = 0;
        has_par[v]  = 0;
        par[v]      = '0;
      end
      if (source_vertex < n) reach[source_vertex] = 1;
      for (int pass = 1; pass < n; pass++) begin
        foreach (edges[k]) begin
          if (try_edge(edges[k], n, sum)) begin
            path_len[edges[k].head] = sum;
            reach[edges[k].head]    = 1;
            has_par[edges[k].head]  = 1;
            par[edges[k].head]      = edges[k].tail;
          end
        end
      end
      clean = 1;
      foreach (edges[k]) begin
        if (clean && try_edge(edges[k], n, sum)) clean = 0;
      end
      for (int v = 0; v < n; v++) begin
        r.vertex       = v[bfsp_pkg::VID_W-1:0];
        r.reachable    = reach[v];
        r.distance     = reach[v] ? path_len[v] : 0;
        r.has_parent   = reach[v] && has_par[v];
        r.parent       = r.has_parent ? par[v] : '0;
        r.no_neg_cycle = clean;
        r.last_vertex  = (v == n - 1);
        pending_vertices = {pending_vertices, r};
      end
    endfunction

    // Called for every accepted edge beat; a full table drops the edge.
    function void note_edge(edge_t e, bit last);
      if (edges.size() < MAX_E) edges = {edges, e};
      if (last) begin
        relax_graph();
        edges.delete();
      end
    endfunction

    function void field_error(string name, logic [bfsp_pkg::VID_W-1:0] vid,
                              logic signed [63:0] want, logic signed [63:0] got);
      $display("%0t: vertex %0d %s expected %0d actual %0d", $time, vid, name, want, got);
      errors++;
    endfunction

    // Compares one result beat with the oldest expected vertex result.
    function void check_result(vertex_result_t got);
      vertex_result_t want;
      if (pending_vertices.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, actual %p", $time, got);
        errors++;
        return;
      end
      want = pending_vertices.pop_front();
      if (got.vertex !== want.vertex)
        field_error("vertex", want.vertex, want.vertex, got.vertex);
      if (got.distance !== want.distance)
        field_error("distance", want.vertex, want.distance, got.distance);
      if (got.reachable !== want.reachable)
        field_error("reachable", want.vertex, want.reachable, got.reachable);
      if (got.parent !== want.parent)
        field_error("parent", want.vertex, want.parent, got.parent);
      if (got.has_parent !== want.has_parent)
        field_error("has_parent", want.vertex, want.has_parent, got.has_parent);
      if (got.no_neg_cycle !== want.no_neg_cycle)
        field_error("no_negative_cycle", want.vertex, want.no_neg_cycle, got.no_neg_cycle);
      if (got.last_vertex !== want.last_vertex)
        field_error("last_vertex", want.vertex, want.last_vertex, got.last_vertex);
    endfunction
  endclass

  logic                            clk;
  logic                            rst_n;
  logic                            cfg_we;
  logic [bfsp_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [bfsp_pkg::CFG_DATA_W-1:0] cfg_wdata;
  logic                            sink_ready = 1'b0;

  bfsp_in_if  in_if();
  bfsp_out_if out_if();

  assign out_if.ready = sink_ready;

  bellman_ford_shortest_paths DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_if),
    .out_ch    (out_if)
  );

  distance_scoreboard sb = new();

  edge_t graph_q[$];
  int    active_n  = 1;
  int    burst_left = 0;
  int    quiet_cycles = 0;
  int    stall_mode = 0;
  int    stall_left = 0;

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Receiver back-pressure: modes of always ready, random, mostly ready and hard stall.
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(4, 40);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: begin
        sink_ready <= 1'b1;
      end
      1: begin
        sink_ready <= 1'($urandom_range(0, 1));
      end
      2: begin
        sink_ready <= ($urandom_range(0, 7) != 0);
      end
      default: begin
        sink_ready <= 1'b0;
      end
    endcase
  end

  // Beat monitors and the quiet-cycle watchdog.
  always @(posedge clk) begin
    if (rst_n && in_if.valid && in_if.ready) begin
      sb.note_edge('{tail: in_if.from_vertex, head: in_if.to_vertex, weight: in_if.weight},
                   in_if.last_edge);
    end
    if (rst_n && out_if.valid && out_if.ready) begin
      sb.check_result('{vertex: out_if.vertex, distance: out_if.distance,
                        reachable: out_if.reachable, parent: out_if.parent,
                        has_parent: out_if.has_parent,
                        no_neg_cycle: out_if.no_negative_cycle,
                        last_vertex: out_if.last_vertex});
    end
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no beat for %0d cycles", $time, QUIET_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic int effective_count(logic [bfsp_pkg::VCNT_W-1:0] c);
    if (c == 0) return 1;
    if (c > MAX_V) return MAX_V;
    return c;
  endfunction

  // Drives one edge beat, then ends the burst with a random gap when it runs out.
  task automatic push_edge(edge_t e, bit last);
    in_if.valid       <= 1'b1;
    in_if.from_vertex <= e.tail;
    in_if.to_vertex   <= e.head;
    in_if.weight      <= e.weight;
    in_if.last_edge   <= last;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 8);
    end
  endtask

  task automatic send_graph();
    foreach (graph_q[k]) push_edge(graph_q[k], k == graph_q.size() - 1);
    graph_q.delete();
  endtask

  function automatic void add_edge(int tail, int head, int w);
    edge_t e;
    e = '{tail: bfsp_pkg::VID_W'(tail), head: bfsp_pkg::VID_W'(head),
          weight: bfsp_pkg::WIN_W'(w)};
    graph_q = {graph_q, e};
  endfunction

  // Holds the sender off until every expected result has arrived, plus a short tail.
  task automatic wait_idle();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Writes both registers, in random order, while the block is idle.
  task automatic configure(logic [bfsp_pkg::CFG_DATA_W-1:0] count_data,
                           logic [bfsp_pkg::CFG_DATA_W-1:0] src_data);
    logic [bfsp_pkg::CFG_IDX_W-1:0] idx;
    bit                             src_first;
    src_first = 1'($urandom_range(0, 1));
    wait_idle();
    for (int k = 0; k < 2; k++) begin
      idx       = ((k == 0) == src_first) ? bfsp_pkg::REG_SOURCE_VERTEX
                                          : bfsp_pkg::REG_VERTEX_COUNT;
      cfg_we    <= 1'b1;
      cfg_index <= idx;
      cfg_wdata <= (idx == bfsp_pkg::REG_SOURCE_VERTEX) ? src_data : count_data;
      @(posedge clk);
      sb.write_reg(idx, (idx == bfsp_pkg::REG_SOURCE_VERTEX) ? src_data : count_data);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
    active_n = effective_count(count_data[bfsp_pkg::VCNT_W-1:0]);
  endtask

  function automatic logic signed [bfsp_pkg::WIN_W-1:0] pick_weight();
    case ($urandom_range(0, 9))
      6: return bfsp_pkg::WIN_W'(-$urandom_range(1, 50));
      7: return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
      8: return bfsp_pkg::WIN_W'($urandom);
      default: return bfsp_pkg::WIN_W'($urandom_range(0, 100));
    endcase
  endfunction

  // Picks a new register setting, mostly small graphs with a legal source.
  task automatic random_config();
    logic [bfsp_pkg::CFG_DATA_W-1:0] count_data;
    int                              n;
    int                              src;
    case ($urandom_range(0, 9))
      0: count_data = 7'd64;
      1: count_data = 7'($urandom_range(65, 127));
      2: count_data = 7'd0;
      3: count_data = 7'd1;
      default: count_data = 7'($urandom_range(2, 16));
    endcase
    n = effective_count(count_data);
    src = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 63) : $urandom_range(0, n - 1);
    configure(count_data, {1'($urandom_range(0, 1)), 6'(src)});
  endtask

  // Builds a graph: adjacency-ordered edges inside the vertex range, or raw noise.
  task automatic build_random_graph(output int edge_cnt);
    int    tails[$];
    int    count;
    bit    noise;
    edge_t e;
    noise = ($urandom_range(0, 9) < 3);
    count = noise ? $urandom_range(1, 8) : $urandom_range(1, 12);
    if (noise) begin
      for (int k = 0; k < count; k++) begin
        e.tail   = bfsp_pkg::VID_W'($urandom);
        e.head   = bfsp_pkg::VID_W'($urandom);
        e.weight = bfsp_pkg::WIN_W'($urandom);
        graph_q  = {graph_q, e};
      end
    end else begin
      for (int k = 0; k < count; k++) tails = {tails, int'($urandom_range(0, active_n - 1))};
      tails.sort();
      foreach (tails[k]) begin
        e.tail   = bfsp_pkg::VID_W'(tails[k]);
        e.head   = bfsp_pkg::VID_W'($urandom_range(0, active_n - 1));
        e.weight = pick_weight();
        graph_q  = {graph_q, e};
      end
    end
    edge_cnt = graph_q.size();
  endtask

  // Main sequence: reset, directed graphs, random graphs, drain.
  initial begin
    int random_items;
    int got;
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = '0;
    cfg_wdata         = '0;
    in_if.valid       = 1'b0;
    in_if.from_vertex = '0;
    in_if.to_vertex   = '0;
    in_if.weight      = '0;
    in_if.last_edge   = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: a single vertex with a negative self-loop.
    add_edge(0, 0, -1);
    send_graph();

    // Extreme weights, an out-of-range head and a negative cycle through the source.
    configure(7'd4, 7'd0);
    add_edge(0, 1, 32767);
    add_edge(0, 63, 5);
    add_edge(1, 2, 32767);
    add_edge(2, 3, -32768);
    add_edge(3, 0, -32768);
    send_graph();

    // A zero count acts as one vertex; the source write carries a stray top bit.
    configure(7'd0, 7'h40);
    add_edge(63, 63, 32767);
    send_graph();

    // An oversized count acts as the full vertex range, source at the top vertex.
    configure(7'd127, 7'd63);
    add_edge(0, 1, 1);
    add_edge(62, 0, 7);
    add_edge(63, 62, -32768);
    send_graph();

    // Source beyond the vertex count leaves everything unreachable.
    configure(7'd3, 7'd5);
    add_edge(0, 1, 4);
    add_edge(1, 2, 4);
    send_graph();

    // Equal-length path must not replace the parent; an unreachable tail never relaxes.
    configure(7'd4, 7'd0);
    add_edge(0, 1, 7);
    add_edge(0, 2, 3);
    add_edge(2, 1, 4);
    add_edge(3, 2, -9);
    send_graph();

    // Random graphs with occasional reconfiguration and full drains.
    random_items = 0;
    while (random_items < RANDOM_EDGES) begin
      if ($urandom_range(0, 3) == 0) begin
        random_config();
      end else if ($urandom_range(0, 5) == 0) begin
        wait_idle();
      end
      build_random_graph(got);
      random_items += got;
      send_graph();
    end

    wait_idle();
    repeat (50) @(posedge clk);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
